[hdl/lgs_pkg.sv]
// Shared types, constants and the life rule for the life generation step block.
`default_nettype none
package lgs_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int ROW_AW    = $clog2(GRID_ROWS);
  localparam int DIM_W     = 7;
  localparam int CNT_W     = 7;

  typedef logic [GRID_COLS-1:0] row_t;
  typedef logic [ROW_AW-1:0]    row_addr_t;
  typedef logic [DIM_W-1:0]     dim_t;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam dim_t DIM_RESET = dim_t'(64);
  localparam dim_t COLS_MAX  = dim_t'(GRID_COLS);
  localparam dim_t ROWS_MAX  = dim_t'(GRID_ROWS);

  // New generation of the middle row from its three-row window.
  function automatic row_t life_row(input row_t above, input row_t here, input row_t below);
    logic [GRID_COLS+1:0] ap;
    logic [GRID_COLS+1:0] hp;
    logic [GRID_COLS+1:0] bp;
    logic [3:0]           n;
    row_t                 res;
    ap = {1'b0, above, 1'b0};
    hp = {1'b0, here, 1'b0};
    bp = {1'b0, below, 1'b0};
    res = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2]) + 4'(hp[c]) + 4'(hp[c+2])
        + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
      res[c] = (n == 4'd3) || (here[c] && (n == 4'd2));
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/lgs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/life_generation_step.sv]
// Top level of the life generation step block: bounded life grid with cell access.
`default_nettype none
// Usage:
//   Command channel: drive start with in_mode/in_row/in_col/in_cell_value; the item
//   is taken at a clock edge where start is high and busy is low. Modes: write cell,
//   advance one generation, read cell; any other code does nothing.
//   Result channel: every item gives one result on out_cell_alive, shown for exactly
//   one cycle with out_valid high. The receiver cannot hold it off.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 width, 1 height) and
//   cfg_data; write only while the block is idle. cfg_ready is always high.
// Timing:
//   Write and read: the row is read in the accepting cycle, then updated or its bit
//   picked while busy; the result shows in the cycle after the busy cycle.
//   An unused mode gives its result in the next cycle with no busy time. An advance
//   sweeps the rows through one shared row evaluator, one row a cycle, as the single
//   read port of the grid RAM feeds the three-row window.
//   A new item may start in the cycle its predecessor's result is shown.
// Reset:
//   All cells read dead: each grid row has a valid flag, cleared by reset, so the
//   RAM itself needs no clearing pass. Width and height return to 64.
module life_generation_step
  import lgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_row,
  input  logic [5:0] in_col,
  input  logic       in_cell_value,
  output logic       out_valid,
  output logic       out_cell_alive,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR   = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_GEN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  row_t             above_r, above_nxt;
  row_t             here_r, here_nxt;
  row_t             below_r, below_nxt;
  logic [GRID_ROWS-1:0] vld_r, vld_nxt;
  logic             vld_q_r;
  row_addr_t        row_r, row_nxt;
  logic [5:0]       col_r, col_nxt;
  logic             val_r, val_nxt;
  logic             inside_r, inside_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_alive_r, out_alive_nxt;
  dim_t             grid_width_r, grid_height_r;

  dim_t             w_used, h_used;
  row_t             wmask;
  row_t             rows_q;
  row_t             row_mod;
  logic [CNT_W-1:0] cnt_m3;
  logic             accept;
  logic             in_inside;

  logic             ram_we;
  row_addr_t        ram_waddr;
  row_t             ram_wdata;
  row_addr_t        ram_raddr;
  row_t             ram_rdata;

  lgs_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clamp dimensions to the grid store.
  assign w_used = (grid_width_r > COLS_MAX) ? COLS_MAX : grid_width_r;
  assign h_used = (grid_height_r > ROWS_MAX) ? ROWS_MAX : grid_height_r;

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      wmask[c] = (dim_t'(c) < w_used);
    end
  end

  // Rows never written since reset, or dropped by an advance, read as dead.
  assign rows_q    = ram_rdata & {GRID_COLS{vld_q_r}};
  assign accept    = start && !busy;
  assign in_inside = ({1'b0, in_row} < h_used) && ({1'b0, in_col} < w_used);
  assign cnt_m3    = cnt_r - CNT_W'(3);

  always_comb begin
    row_mod         = rows_q;
    row_mod[col_r]  = val_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    above_nxt     = above_r;
    here_nxt      = here_r;
    below_nxt     = below_r;
    vld_nxt       = vld_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    inside_nxt    = inside_r;
    out_valid_nxt = 1'b0;
    out_alive_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = row_r;
    ram_wdata     = row_mod;
    ram_raddr     = in_row;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          row_nxt    = in_row;
          col_nxt    = in_col;
          val_nxt    = in_cell_value;
          inside_nxt = in_inside;
          case (in_mode)
            MODE_WRITE: begin
              state_nxt = ST_WR;
            end
            MODE_READ: begin
              state_nxt = ST_RD;
            end
            MODE_ADVANCE: begin
              // Start the sweep with an empty window; drop rows beyond the height.
              state_nxt = ST_GEN;
              cnt_nxt   = '0;
              above_nxt = '0;
              here_nxt  = '0;
              below_nxt = '0;
              for (int r = 0; r < GRID_ROWS; r++) begin
                if (!(dim_t'(r) < h_used)) begin
                  vld_nxt[r] = 1'b0;
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_WR: begin
        // Merge the new cell into the row just read and store it back.
        ram_we = inside_r;
        if (inside_r) begin
          vld_nxt[row_r] = 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_RD: begin
        out_valid_nxt = 1'b1;
        out_alive_nxt = inside_r && rows_q[col_r];
        state_nxt     = ST_IDLE;
      end

      ST_GEN: begin
        // Read row cnt; its data arrives next cycle and shifts into the window.
        ram_raddr = cnt_r[ROW_AW-1:0];
        if ((cnt_r >= CNT_W'(1)) && (cnt_r <= CNT_W'(h_used) + CNT_W'(1))) begin
          above_nxt = here_r;
          here_nxt  = below_r;
          below_nxt = (cnt_r <= CNT_W'(h_used)) ? (rows_q & wmask) : '0;
        end
        // Window centered on row cnt-3: write its new generation in place.
        if (cnt_r >= CNT_W'(3)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m3[ROW_AW-1:0];
          ram_wdata = life_row(above_r, here_r, below_r) & wmask;
          vld_nxt[cnt_m3[ROW_AW-1:0]] = 1'b1;
        end
        if (cnt_r == CNT_W'(h_used) + CNT_W'(2)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      vld_r         <= '0;
      out_valid_r   <= 1'b0;
      out_alive_r   <= 1'b0;
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_alive_r <= out_alive_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WIDTH) begin
          grid_width_r <= cfg_data;
        end else if (cfg_index == CFG_IDX_HEIGHT) begin
          grid_height_r <= cfg_data;
        end
      end
    end
  end

  // Payload: window, held command fields and the valid flag of the row being read.
  always_ff @(posedge clk) begin
    above_r  <= above_nxt;
    here_r   <= here_nxt;
    below_r  <= below_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    val_r    <= val_nxt;
    inside_r <= inside_nxt;
    vld_q_r  <= vld_r[ram_raddr];
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_alive_r;
  assign cfg_ready      = 1'b1;

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the life generation step block: directed and random cell traffic.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgs_pkg::*;

  // Command code that the block must ignore (result zero, no state change).
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int ITEM_TARGET  = 1850;  // stop random traffic once this many items are in
  localparam int SETTLE_TICKS = 70;    // longest advance at full height plus margin
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up

  // One outstanding result: what was sent, and what must come back.
  typedef struct {
    logic [1:0] mode;
    logic [5:0] row;
    logic [5:0] col;
    logic       alive;
  } cell_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_mode;
  logic [5:0] in_row;
  logic [5:0] in_col;
  logic       in_cell_value;
  logic       out_valid;
  logic       out_cell_alive;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;

  // Mirror of the grid and of the two size registers.
  row_t cell_rows [GRID_ROWS];
  dim_t cols_setting;
  dim_t rows_setting;

  cell_result_t pending_cells[$];
  int           error_count = 0;
  int           items_sent  = 0;
  int           stall_cycles = 0;
  bit           no_idle = 1'b0;

  life_generation_step dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_cell_alive(out_cell_alive),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  // Sizes above the store saturate; 0 and 1 are taken as they are.
  function automatic int cols_in_use();
    return (cols_setting > COLS_MAX) ? GRID_COLS : int'(cols_setting);
  endfunction

  function automatic int rows_in_use();
    return (rows_setting > ROWS_MAX) ? GRID_ROWS : int'(rows_setting);
  endfunction

  // Anything left or right of the used columns is a dead neighbor.
  function automatic int cell_at(input row_t word, input int c, input int w);
    if (c < 0 || c >= w) return 0;
    return int'(word[c]);
  endfunction

  // Build the whole new generation from the old one, then swap it in. Rows and
  // columns outside the used area come out dead, which also wipes stale cells.
  function automatic void next_generation();
    row_t fresh [GRID_ROWS];
    row_t keep;
    row_t above;
    row_t here;
    row_t below;
    int   w;
    int   h;
    int   n;
    w = cols_in_use();
    h = rows_in_use();
    keep = (w >= GRID_COLS) ? '1 : row_t'((64'd1 << w) - 64'd1);
    for (int r = 0; r < GRID_ROWS; r++) begin
      fresh[r] = '0;
      if (r < h) begin
        above = (r > 0) ? (cell_rows[r-1] & keep) : '0;
        here  = cell_rows[r] & keep;
        below = (r + 1 < h) ? (cell_rows[r+1] & keep) : '0;
        for (int c = 0; c < w; c++) begin
          n = cell_at(above, c - 1, w) + cell_at(above, c, w) + cell_at(above, c + 1, w)
            + cell_at(here, c - 1, w) + cell_at(here, c + 1, w)
            + cell_at(below, c - 1, w) + cell_at(below, c, w) + cell_at(below, c + 1, w);
          fresh[r][c] = here[c] ? (n == 2 || n == 3) : (n == 3);
        end
      end
    end
    cell_rows = fresh;
  endfunction

  // Apply one accepted item to the mirror and return the cell_alive it must give.
  function automatic logic apply_item(input logic [1:0] mode, input logic [5:0] row,
                                      input logic [5:0] col, input logic value);
    logic on_grid;
    on_grid = (int'(row) < rows_in_use()) && (int'(col) < cols_in_use());
    case (mode)
      MODE_WRITE: begin
        if (on_grid) cell_rows[row][col] = value;
      end
      MODE_ADVANCE: begin
        next_generation();
      end
      MODE_READ: begin
        if (on_grid) return cell_rows[row][col];
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one item. Start is left high on return so that a following item goes
  // out back to back; every caller either sends again or lowers it in the same
  // step. Idle now and then before raising start, sometimes long enough to
  // land in the middle of an advance sweep.
  task automatic send_item(input logic [1:0] mode, input logic [5:0] row,
                           input logic [5:0] col, input logic value);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 9)
      gap = ($urandom_range(3) == 0) ? $urandom_range(80, 1) : $urandom_range(4, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_mode       <= mode;
    in_row        <= row;
    in_col        <= col;
    in_cell_value <= value;
    // The item is taken at the first edge where the block is not busy.
    do @(posedge clk); while (busy !== 1'b0);
    pending_cells.push_back('{mode, row, col, apply_item(mode, row, col, value)});
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // Hold start low until every outstanding result is back. Always wait on the
  // clock first so start is never lowered and raised in one step.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_cells.size() != 0);
  endtask

  // Write both size registers while the block sits idle.
  task automatic set_grid_size(input dim_t cols, input dim_t rows);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= cols;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cols_setting = cols;
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= rows;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    rows_setting = rows;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Results cannot be held off: take each one at the edge that ends its cycle.
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("result cell_alive=%b with nothing outstanding",
                                  out_cell_alive));
      end else begin
        want = pending_cells.pop_front();
        if (out_valid !== 1'b1 || out_cell_alive !== want.alive)
          report_mismatch($sformatf("mode %0d row %0d col %0d: cell_alive %b, expected %b",
                                    want.mode, want.row, want.col, out_cell_alive,
                                    want.alive));
      end
    end
  end

  // Count cycles without any handshake; give up if the block goes quiet.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL life_generation_step");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full 64x64 grid straight out of reset: corners, a blinker on the top edge,
  // a block in the far corner, a cleared cell and the unused code.
  task automatic test_directed_cells();
    send_item(MODE_READ, 6'd0, 6'd0, 1'b0);           // reset grid reads dead
    send_item(MODE_READ, 6'd63, 6'd63, 1'b1);
    send_item(MODE_WRITE, 6'd0, 6'd0, 1'b1);          // blinker against the top edge
    send_item(MODE_WRITE, 6'd0, 6'd1, 1'b1);
    send_item(MODE_WRITE, 6'd0, 6'd2, 1'b1);
    send_item(MODE_WRITE, 6'd63, 6'd63, 1'b1);        // L in the far corner grows a block
    send_item(MODE_WRITE, 6'd62, 6'd63, 1'b1);
    send_item(MODE_WRITE, 6'd63, 6'd62, 1'b1);
    send_item(MODE_WRITE, 6'd31, 6'd31, 1'b1);        // set, then clear again
    send_item(MODE_WRITE, 6'd31, 6'd31, 1'b0);
    send_item(MODE_UNUSED, 6'd63, 6'd63, 1'b1);       // must change nothing
    send_item(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
    send_item(MODE_READ, 6'd0, 6'd1, 1'b0);
    send_item(MODE_READ, 6'd1, 6'd1, 1'b0);
    send_item(MODE_READ, 6'd62, 6'd62, 1'b0);
    send_item(MODE_READ, 6'd31, 6'd31, 1'b0);
    send_item(MODE_ADVANCE, 6'd63, 6'd63, 1'b1);
    send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
    send_item(MODE_READ, 6'd0, 6'd1, 1'b0);
    send_item(MODE_READ, 6'd63, 6'd63, 1'b0);
  endtask

  // Poke the corners and the first row and column past the edge of the grid.
  task automatic probe_edges();
    logic [5:0] row_end;
    logic [5:0] col_end;
    row_end = (rows_setting > dim_t'(63)) ? 6'd63 : 6'(rows_setting);
    col_end = (cols_setting > dim_t'(63)) ? 6'd63 : 6'(cols_setting);
    send_item(MODE_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(MODE_WRITE, 6'd0, 6'd1, 1'b1);
    send_item(MODE_WRITE, 6'd1, 6'd0, 1'b1);
    send_item(MODE_WRITE, row_end, 6'd0, 1'b1);       // outside unless the size saturates
    send_item(MODE_WRITE, 6'd0, col_end, 1'b1);
    send_item(MODE_ADVANCE, 6'd63, 6'd63, 1'b1);
    send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
    send_item(MODE_READ, 6'd1, 6'd1, 1'b0);
    send_item(MODE_READ, row_end, 6'd0, 1'b0);
    send_item(MODE_READ, 6'd0, col_end, 1'b0);
    send_item(MODE_READ, 6'd63, 6'd63, 1'b0);
  endtask

  // Empty, one-wide, one-high, minimum and oversized grids, then cells left
  // behind by shrinking the grid.
  task automatic test_dimension_edges();
    set_grid_size(dim_t'(0), dim_t'(0));
    probe_edges();
    set_grid_size(dim_t'(1), dim_t'(1));
    probe_edges();
    set_grid_size(dim_t'(1), dim_t'(5));
    probe_edges();
    set_grid_size(dim_t'(5), dim_t'(1));
    probe_edges();
    set_grid_size(dim_t'(2), dim_t'(2));
    probe_edges();
    set_grid_size(dim_t'(127), dim_t'(127));
    probe_edges();
    set_grid_size(dim_t'(65), dim_t'(3));
    probe_edges();
    set_grid_size(dim_t'(3), dim_t'(65));
    probe_edges();

    // Plant cells just outside a 4x4 area, shrink to it, and check they
    // neither count as neighbors nor survive the next generation.
    set_grid_size(dim_t'(64), dim_t'(64));
    send_item(MODE_WRITE, 6'd3, 6'd4, 1'b1);
    send_item(MODE_WRITE, 6'd4, 6'd3, 1'b1);
    send_item(MODE_WRITE, 6'd4, 6'd4, 1'b1);
    send_item(MODE_WRITE, 6'd2, 6'd2, 1'b1);
    send_item(MODE_WRITE, 6'd2, 6'd3, 1'b1);
    set_grid_size(dim_t'(4), dim_t'(4));
    send_item(MODE_READ, 6'd3, 6'd4, 1'b0);
    send_item(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_item(MODE_READ, 6'd3, 6'd3, 1'b0);
    send_item(MODE_READ, 6'd2, 6'd2, 1'b0);
    set_grid_size(dim_t'(64), dim_t'(64));
    send_item(MODE_READ, 6'd4, 6'd4, 1'b0);
    send_item(MODE_READ, 6'd3, 6'd4, 1'b0);
  endtask

  // Mostly well-formed rounds: seed a pattern, run a few generations and read
  // cells back. The rest is unconstrained noise over every code and address.
  task automatic test_random_generations();
    int pick;
    int cols_now;
    int rows_now;
    int seed_cells;
    while (items_sent < ITEM_TARGET) begin
      // Run one stretch with the sender never idling.
      no_idle = (items_sent >= 600 && items_sent < 950);

      // Change size now and then; small grids most of the time so the
      // generations evolve quickly, with the full range mixed in.
      pick = $urandom_range(99);
      if (pick < 35)
        set_grid_size(dim_t'($urandom_range(12, 2)), dim_t'($urandom_range(12, 2)));
      else if (pick < 42)
        set_grid_size(dim_t'($urandom_range(64, 13)), dim_t'($urandom_range(64, 13)));
      else if (pick < 47)
        set_grid_size(dim_t'($urandom_range(127)), dim_t'($urandom_range(127)));
      else if (pick < 55)
        drain_results();                              // pause until all results are in

      cols_now = cols_in_use();
      rows_now = rows_in_use();
      if ($urandom_range(99) < 80 && cols_now > 0 && rows_now > 0) begin
        seed_cells = $urandom_range((cols_now * rows_now < 40) ? cols_now * rows_now : 40, 1);
        repeat (seed_cells)
          send_item(MODE_WRITE, 6'($urandom_range(rows_now - 1)),
                    6'($urandom_range(cols_now - 1)), $urandom_range(99) < 60);
        repeat ($urandom_range(4, 1)) begin
          send_item(MODE_ADVANCE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                    1'($urandom_range(1)));
          repeat ($urandom_range(8, 2))
            send_item(MODE_READ, 6'($urandom_range(rows_now - 1)),
                      6'($urandom_range(cols_now - 1)), 1'($urandom_range(1)));
        end
      end else begin
        repeat ($urandom_range(12, 4))
          send_item(2'($urandom_range(3)), 6'($urandom_range(63)), 6'($urandom_range(63)),
                    1'($urandom_range(1)));
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_mode       <= MODE_WRITE;
    in_row        <= '0;
    in_col        <= '0;
    in_cell_value <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_IDX_WIDTH;
    cfg_data      <= '0;
    // Reset state of the mirror: every cell dead, full 64x64 grid.
    for (int r = 0; r < GRID_ROWS; r++) cell_rows[r] = '0;
    cols_setting = DIM_RESET;
    rows_setting = DIM_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cells();
    test_dimension_edges();
    test_random_generations();

    // Let every result come home, then give the block time to show anything extra.
    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS life_generation_step");
    end else begin
      $display("FAIL life_generation_step");
    end
    $finish;
  end

endmodule
`default_nettype wire
